@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the XMODEM checksum receiver.
// Depends on nothing; users must have signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define XMCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define XMCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/xmcr_pkg.sv @@
// Package for the XMODEM checksum receiver: sizes, protocol codes,
// phase type, result type and the offset helper. Depends on nothing.
package xmcr_pkg;

    localparam int COUNT_WIDTH   = 24;
    localparam int PAYLOAD_BYTES = 128;
    localparam int OFFSET_W      = 24;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES + 4);
    localparam int SUM_W         = (COUNT_WIDTH > OFFSET_W) ? COUNT_WIDTH : OFFSET_W;

    // Packet byte positions: sequence, complement, first payload, checksum.
    localparam logic [IDX_W-1:0] IDX_SEQ   = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_CMPL  = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_DATA  = IDX_W'(3);
    localparam logic [IDX_W-1:0] IDX_CHECK = IDX_W'(PAYLOAD_BYTES + 3);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] COUNT_STEP  = COUNT_WIDTH'(PAYLOAD_BYTES);
    localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = COUNT_MAX - COUNT_STEP;

    localparam logic [7:0] CODE_SOH = 8'h01;
    localparam logic [7:0] CODE_EOT = 8'h04;
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;
    localparam logic [7:0] CODE_CAN = 8'h18;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;
    localparam logic OUT_REPLY    = 1'b0;
    localparam logic OUT_PAYLOAD  = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PACKET = 2'd1,
        PH_DROP   = 2'd2
    } phase_t;

    typedef struct packed {
        logic                out_kind;
        logic [7:0]          out_byte;
        logic [OFFSET_W-1:0] out_offset;
        logic                transfer_done;
        logic                count_overflow;
    } result_t;

    function automatic logic [OFFSET_W-1:0] to_offset(input logic [COUNT_WIDTH-1:0] count);
        logic [SUM_W-1:0] wide;
        wide = SUM_W'(count);
        return wide[OFFSET_W-1:0];
    endfunction

endpackage

@@ hw/rtl/xmcr_if.sv @@
// Valid/ready channel interfaces of the XMODEM checksum receiver:
// the event channel in and the result channel out. Depends on xmcr_pkg.
interface xmcr_evt_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface xmcr_res_if;
    logic                          valid;
    logic                          ready;
    logic                          out_kind;
    logic [7:0]                    out_byte;
    logic [xmcr_pkg::OFFSET_W-1:0] out_offset;
    logic                          transfer_done;
    logic                          count_overflow;

    modport source (output valid, output out_kind, output out_byte, output out_offset,
                    output transfer_done, output count_overflow, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input out_offset,
                    input transfer_done, input count_overflow, output ready);
endinterface

@@ hw/rtl/xmodem_checksum_receiver.sv @@
// Top level of the XMODEM receiver with 8-bit additive checksum.
// Depends on xmcr_pkg, the interfaces in xmcr_if.sv and assert_macros.svh.
//
//   channel | dir | beat carries
//   --------+-----+---------------------------------------------------------
//   evt     | in  | kind (byte or timeout), rx_byte
//   res     | out | out_kind, out_byte, out_offset, transfer_done,
//           |     | count_overflow
//
// One event beat is taken per cycle while evt.ready is high. A beat waits in
// the input register, is decoded there, and its result (if any) is captured
// in the output register at the edge where the beat leaves the input register.
// All control state resets asynchronously on rst_n low.
// A stalled result holds the output register; the held event then waits
// in the input register, and evt.ready drops only when both are full.

`include "assert_macros.svh"

module xmodem_checksum_receiver (
    input  logic              clk,
    input  logic              rst_n,
    xmcr_evt_if.sink          evt,
    xmcr_res_if.source        res
);

    // Input register: one event waiting to be decoded.
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;

    // Protocol state.
    xmcr_pkg::phase_t                   phase_reg, phase_next;
    logic [xmcr_pkg::IDX_W-1:0]         packet_index_reg, packet_index_next;
    logic [7:0]                         expected_seq_reg, expected_seq_next;
    logic [xmcr_pkg::COUNT_WIDTH-1:0]   committed_count_reg, committed_count_next;
    logic [7:0]                         running_sum_reg, running_sum_next;
    logic                               header_ok_reg, header_ok_next;
    logic                               packet_seen_reg, packet_seen_next;

    // Output register.
    logic                               out_valid_reg, out_valid_next;
    xmcr_pkg::result_t                  out_reg, out_next;

    logic                               proc_fire;
    logic                               in_ready;
    logic                               is_timeout;
    logic [xmcr_pkg::COUNT_WIDTH-1:0]   commit_count;
    logic                               count_full;
    logic                               checksum_good;

    // The held event is decoded when the output register can take its result.
    assign proc_fire  = in_valid_reg && (!out_valid_reg || res.ready);
    assign in_ready   = !in_valid_reg || proc_fire;
    assign evt.ready  = in_ready;
    assign is_timeout = (in_kind_reg == xmcr_pkg::KIND_TIMEOUT);

    // Count after a good packet, saturating at the top of the counter.
    assign commit_count  = (committed_count_reg > xmcr_pkg::COUNT_LIMIT)
                         ? xmcr_pkg::COUNT_MAX
                         : committed_count_reg + xmcr_pkg::COUNT_STEP;
    assign count_full    = (committed_count_reg == xmcr_pkg::COUNT_MAX);
    assign checksum_good = header_ok_reg && (in_byte_reg == running_sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && evt.valid)
        begin
            in_kind_reg <= evt.kind;
            in_byte_reg <= evt.rx_byte;
        end
    end

    // Next protocol state.
    always_comb
    begin
        phase_next           = phase_reg;
        packet_index_next    = packet_index_reg;
        expected_seq_next    = expected_seq_reg;
        committed_count_next = committed_count_reg;
        running_sum_next     = running_sum_reg;
        header_ok_next       = header_ok_reg;
        packet_seen_next     = packet_seen_reg;
        if (proc_fire)
        begin
            unique case (phase_reg)
                xmcr_pkg::PH_PACKET:
                begin
                    priority if (is_timeout)
                    begin
                        phase_next        = xmcr_pkg::PH_IDLE;
                        packet_index_next = '0;
                    end
                    else if (packet_index_reg == xmcr_pkg::IDX_SEQ)
                    begin
                        header_ok_next    = (in_byte_reg == expected_seq_reg);
                        packet_index_next = xmcr_pkg::IDX_CMPL;
                    end
                    else if (packet_index_reg == xmcr_pkg::IDX_CMPL)
                    begin
                        header_ok_next    = header_ok_reg && (in_byte_reg == ~expected_seq_reg);
                        packet_index_next = xmcr_pkg::IDX_DATA;
                    end
                    else if (packet_index_reg < xmcr_pkg::IDX_CHECK)
                    begin
                        running_sum_next  = running_sum_reg + in_byte_reg;
                        packet_index_next = packet_index_reg + 1'b1;
                    end
                    else
                    begin
                        packet_index_next = '0;
                        if (checksum_good)
                        begin
                            committed_count_next = commit_count;
                            expected_seq_next    = expected_seq_reg + 8'd1;
                            phase_next           = xmcr_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next = xmcr_pkg::PH_DROP;
                        end
                    end
                end
                xmcr_pkg::PH_DROP:
                begin
                    if (is_timeout)
                    begin
                        phase_next = xmcr_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    // Idle, and any unused phase code, which behaves as idle.
                    phase_next = xmcr_pkg::PH_IDLE;
                    if (!is_timeout)
                    begin
                        priority if (in_byte_reg == xmcr_pkg::CODE_SOH)
                        begin
                            phase_next        = xmcr_pkg::PH_PACKET;
                            packet_index_next = xmcr_pkg::IDX_SEQ;
                            running_sum_next  = 8'd0;
                            header_ok_next    = 1'b0;
                            packet_seen_next  = 1'b1;
                        end
                        else if (in_byte_reg == xmcr_pkg::CODE_EOT ||
                                 in_byte_reg == xmcr_pkg::CODE_CAN)
                        begin
                            // Both end the transfer and start over as after reset.
                            packet_index_next    = '0;
                            expected_seq_next    = 8'd1;
                            committed_count_next = '0;
                            running_sum_next     = 8'd0;
                            header_ok_next       = 1'b0;
                            packet_seen_next     = 1'b0;
                        end
                        else
                        begin
                            phase_next = xmcr_pkg::PH_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    // Result of the held event.
    always_comb
    begin
        out_valid_next          = 1'b0;
        out_next.out_kind       = xmcr_pkg::OUT_REPLY;
        out_next.out_byte       = xmcr_pkg::CODE_NAK;
        out_next.out_offset     = xmcr_pkg::to_offset(committed_count_reg);
        out_next.transfer_done  = 1'b0;
        out_next.count_overflow = count_full;
        unique case (phase_reg)
            xmcr_pkg::PH_PACKET:
            begin
                priority if (is_timeout)
                begin
                    out_valid_next = 1'b1;
                end
                else if (packet_index_reg == xmcr_pkg::IDX_SEQ ||
                         packet_index_reg == xmcr_pkg::IDX_CMPL)
                begin
                    out_valid_next = 1'b0;
                end
                else if (packet_index_reg < xmcr_pkg::IDX_CHECK)
                begin
                    // Tentative write at the committed count plus payload index.
                    out_valid_next      = 1'b1;
                    out_next.out_kind   = xmcr_pkg::OUT_PAYLOAD;
                    out_next.out_byte   = in_byte_reg;
                    out_next.out_offset = xmcr_pkg::to_offset(committed_count_reg)
                        + xmcr_pkg::OFFSET_W'(packet_index_reg - xmcr_pkg::IDX_DATA);
                end
                else if (checksum_good)
                begin
                    out_valid_next          = 1'b1;
                    out_next.out_byte       = xmcr_pkg::CODE_ACK;
                    out_next.out_offset     = xmcr_pkg::to_offset(commit_count);
                    out_next.count_overflow = (commit_count == xmcr_pkg::COUNT_MAX);
                end
                else
                begin
                    out_valid_next = 1'b0;
                end
            end
            xmcr_pkg::PH_DROP:
            begin
                out_valid_next = is_timeout;
            end
            default:
            begin
                priority if (!is_timeout && in_byte_reg == xmcr_pkg::CODE_SOH)
                begin
                    out_valid_next = 1'b0;
                end
                else if (!is_timeout && in_byte_reg == xmcr_pkg::CODE_EOT)
                begin
                    // Reports the final count before the restart clears it.
                    out_valid_next         = 1'b1;
                    out_next.out_byte      = xmcr_pkg::CODE_ACK;
                    out_next.transfer_done = 1'b1;
                end
                else if (!is_timeout && in_byte_reg == xmcr_pkg::CODE_CAN)
                begin
                    out_valid_next          = 1'b1;
                    out_next.out_byte       = xmcr_pkg::CODE_ACK;
                    out_next.out_offset     = '0;
                    out_next.count_overflow = 1'b0;
                end
                else
                begin
                    // Before the first packet, anything else is answered by NAK;
                    // after one, it is ignored so no old reply is repeated.
                    out_valid_next = !packet_seen_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= xmcr_pkg::PH_IDLE;
            packet_index_reg    <= '0;
            expected_seq_reg    <= 8'd1;
            committed_count_reg <= '0;
            running_sum_reg     <= 8'd0;
            header_ok_reg       <= 1'b0;
            packet_seen_reg     <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg           <= phase_next;
            packet_index_reg    <= packet_index_next;
            expected_seq_reg    <= expected_seq_next;
            committed_count_reg <= committed_count_next;
            running_sum_reg     <= running_sum_next;
            header_ok_reg       <= header_ok_next;
            packet_seen_reg     <= packet_seen_next;
            if (proc_fire)
            begin
                out_valid_reg <= out_valid_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.out_kind       = out_reg.out_kind;
    assign res.out_byte       = out_reg.out_byte;
    assign res.out_offset     = out_reg.out_offset;
    assign res.transfer_done  = out_reg.transfer_done;
    assign res.count_overflow = out_reg.count_overflow;

    // The end-of-transfer flag only ever rides on an ACK reply.
    `XMCR_ASSERT_SAME(a_done_is_ack, res.valid && res.transfer_done,
        res.out_kind == xmcr_pkg::OUT_REPLY && res.out_byte == xmcr_pkg::CODE_ACK,
        "transfer_done on a beat that is not an ACK reply")
    // A dropped packet has already rewound its byte index.
    `XMCR_ASSERT_SAME(a_drop_index_clear, phase_reg == xmcr_pkg::PH_DROP,
        packet_index_reg == '0, "packet index not cleared while dropping")
    // Payload writes come only from the packet phase.
    `XMCR_ASSERT_NEXT(a_payload_from_packet,
        proc_fire && out_valid_next && out_next.out_kind == xmcr_pkg::OUT_PAYLOAD,
        $past(phase_reg) == xmcr_pkg::PH_PACKET, "payload write outside a packet")

endmodule

@@ bench/xmcr_reply_checker.sv @@
// Result checker for the XMODEM checksum receiver: watches both channels,
// predicts every reply and payload write, and counts mismatches.
// Depends on xmcr_pkg and the channel interfaces in xmcr_if.sv.
module xmcr_reply_checker
    import xmcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    xmcr_evt_if  evt,
    xmcr_res_if  res,
    output int   failures,
    output int   pending
);

    localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = '1;

    phase_t                 phase;
    int unsigned            pkt_pos;
    logic [7:0]             seq_due;
    logic [COUNT_WIDTH-1:0] committed;
    logic [7:0]             sum;
    logic                   header_good;
    logic                   packet_seen;
    result_t                replies_due[$];
    int                     err_count;
    int                     due_count;

    assign failures = err_count;
    assign pending  = due_count;

    task automatic clear_transfer();
        phase       = PH_IDLE;
        pkt_pos     = 0;
        seq_due     = 8'd1;
        committed   = '0;
        sum         = 8'd0;
        header_good = 1'b0;
        packet_seen = 1'b0;
    endtask

    // The overflow flag reflects the committed count as it stands when the result is made.
    function automatic result_t make_result(input logic k, input logic [7:0] b,
                                            input longint unsigned off, input logic done);
        result_t r;
        r.out_kind       = k;
        r.out_byte       = b;
        r.out_offset     = OFFSET_W'(off);
        r.transfer_done  = done;
        r.count_overflow = (committed == FULL_COUNT);
        return r;
    endfunction

    task automatic decode_event(input logic tmo, input logic [7:0] b,
                                output bit has, output result_t r);
        logic [COUNT_WIDTH-1:0] room;
        has = 1'b0;
        r   = '0;
        case (phase)
            PH_PACKET:
            begin
                if (tmo)
                begin
                    phase   = PH_IDLE;
                    pkt_pos = 0;
                    has     = 1'b1;
                    r       = make_result(OUT_REPLY, CODE_NAK, committed, 1'b0);
                end
                else if (pkt_pos == 1)
                begin
                    header_good = (b == seq_due);
                    pkt_pos     = 2;
                end
                else if (pkt_pos == 2)
                begin
                    header_good = header_good && (b == ~seq_due);
                    pkt_pos     = 3;
                end
                else if (pkt_pos < PAYLOAD_BYTES + 3)
                begin
                    has     = 1'b1;
                    r       = make_result(OUT_PAYLOAD, b,
                                          longint'(committed) + (pkt_pos - 3), 1'b0);
                    sum     = sum + b;
                    pkt_pos = pkt_pos + 1;
                end
                else
                begin
                    pkt_pos = 0;
                    if (header_good && b == sum)
                    begin
                        room      = FULL_COUNT - committed;
                        committed = (room < COUNT_WIDTH'(PAYLOAD_BYTES)) ? FULL_COUNT
                                  : committed + COUNT_WIDTH'(PAYLOAD_BYTES);
                        seq_due   = seq_due + 8'd1;
                        phase     = PH_IDLE;
                        has       = 1'b1;
                        r         = make_result(OUT_REPLY, CODE_ACK, committed, 1'b0);
                    end
                    else
                    begin
                        phase = PH_DROP;
                    end
                end
            end
            PH_DROP:
            begin
                if (tmo)
                begin
                    phase = PH_IDLE;
                    has   = 1'b1;
                    r     = make_result(OUT_REPLY, CODE_NAK, committed, 1'b0);
                end
            end
            default:
            begin
                phase = PH_IDLE;
                if (!tmo && b == CODE_SOH)
                begin
                    phase       = PH_PACKET;
                    pkt_pos     = 1;
                    sum         = 8'd0;
                    header_good = 1'b0;
                    packet_seen = 1'b1;
                end
                else if (!tmo && b == CODE_EOT)
                begin
                    has = 1'b1;
                    r   = make_result(OUT_REPLY, CODE_ACK, committed, 1'b1);
                    clear_transfer();
                end
                else if (!tmo && b == CODE_CAN)
                begin
                    clear_transfer();
                    has = 1'b1;
                    r   = make_result(OUT_REPLY, CODE_ACK, committed, 1'b0);
                end
                else if (!packet_seen)
                begin
                    has = 1'b1;
                    r   = make_result(OUT_REPLY, CODE_NAK, committed, 1'b0);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    initial
    begin
        err_count = 0;
        due_count = 0;
        clear_transfer();
    end

    always @(posedge clk)
    begin : watch
        result_t want;
        bit      produced;
        if (!rst_n)
        begin
            clear_transfer();
            replies_due.delete();
        end
        else
        begin
            // Results leave only after their event has passed the input and output registers, so the
            // result side is checked before this edge's event is predicted.
            if (res.valid && res.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    report_mismatch("result beat with nothing expected",
                                    {res.out_kind, res.out_byte, res.out_offset}, 0);
                end
                else
                begin
                    want = replies_due.pop_front();
                    compare_field("out_kind", res.out_kind, want.out_kind);
                    compare_field("out_byte", res.out_byte, want.out_byte);
                    compare_field("out_offset", res.out_offset, want.out_offset);
                    compare_field("transfer_done", res.transfer_done, want.transfer_done);
                    compare_field("count_overflow", res.count_overflow,
                                  want.count_overflow);
                end
            end
            if (evt.valid && evt.ready)
            begin
                decode_event(evt.kind, evt.rx_byte, produced, want);
                if (produced)
                    replies_due.push_back(want);
            end
            due_count = replies_due.size();
        end
    end

endmodule

@@ bench/xmodem_checksum_receiver_test.sv @@
// Top of the XMODEM checksum receiver testbench: clock, reset, event
// stimulus, result back-pressure and the verdict.
// Depends on xmcr_pkg, xmcr_if.sv, the block itself and xmcr_reply_checker.
module xmodem_checksum_receiver_test;
    import xmcr_pkg::*;

    // Ways a generated packet can be spoiled.
    typedef enum int {
        FLAW_NONE,
        FLAW_SEQ,
        FLAW_CMPL,
        FLAW_SUM
    } flaw_t;

    localparam int FRAME_LEN  = PAYLOAD_BYTES + 3;   // seq, complement, data, checksum
    localparam int ITEM_COUNT = 600;
    localparam int HOLD_BEATS = 400;

    logic       clk = 1'b0;
    logic       rst_n;
    int         failures;
    int         pending;
    int         sent = 0;
    bit         no_gaps = 1'b0;        // both sides run flat out while set
    bit         hold_request = 1'b0;   // asks the result side for one long stall
    logic [7:0] next_seq = 8'd1;       // sequence number the block should want next

    xmcr_evt_if evt_ch ();
    xmcr_res_if res_ch ();

    xmodem_checksum_receiver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch)
    );

    xmcr_reply_checker reply_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt_ch),
        .res      (res_ch),
        .failures (failures),
        .pending  (pending)
    );

    always #5 clk = ~clk;

    // Hard stop in case the block hangs or drops a handshake.
    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Offers one event beat after a random gap and returns at the edge where
    // it is taken. Valid stays high on return, so a following beat with no
    // gap goes out back to back without valid ever being touched twice in
    // one time step.
    task automatic send_beat(input logic k, input logic [7:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid   <= 1'b1;
        evt_ch.kind    <= k;
        evt_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!evt_ch.ready);
        sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(KIND_BYTE, b);
    endtask

    // The byte lane carries junk on a timeout; the block must ignore it.
    task automatic send_timeout();
        send_beat(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
    endtask

    // Lets the event side go quiet until every predicted result has come out.
    task automatic wait_replies_drained();
        evt_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Payload data: mostly uniform, or heavy on protocol codes so the block
    // has to treat them as plain data inside a packet.
    function automatic logic [7:0] payload_byte(input bit ctrl_heavy);
        if (ctrl_heavy && $urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 6))
                0: return CODE_SOH;
                1: return CODE_EOT;
                2: return CODE_CAN;
                3: return CODE_ACK;
                4: return CODE_NAK;
                5: return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Sends SOH and then `keep` frame bytes. A short frame ends in a timeout
    // (NAK mid-packet). A full bad frame is followed by a few dropped bytes
    // and a timeout. A full good frame advances the expected sequence.
    task automatic send_packet(input flaw_t flaw, input int keep, input bit ctrl_heavy);
        logic [7:0] frame [FRAME_LEN];
        logic [7:0] csum;
        int         len;
        csum = 8'd0;
        frame[0] = next_seq;
        if (flaw == FLAW_SEQ)
        begin
            // Half the time a repeat of the previous packet's number.
            frame[0] = ($urandom_range(0, 1) == 0) ? next_seq - 8'd1
                     : next_seq + 8'($urandom_range(1, 255));
            if (frame[0] == next_seq)
                frame[0] = next_seq + 8'd1;
        end
        frame[1] = ~next_seq;
        if (flaw == FLAW_CMPL)
            frame[1] = frame[1] ^ 8'($urandom_range(1, 255));
        for (int i = 2; i < FRAME_LEN - 1; i++)
        begin
            frame[i] = payload_byte(ctrl_heavy);
            csum     = csum + frame[i];
        end
        frame[FRAME_LEN-1] = csum;
        if (flaw == FLAW_SUM)
            frame[FRAME_LEN-1] = csum ^ 8'($urandom_range(1, 255));

        len = (keep < FRAME_LEN) ? keep : FRAME_LEN;
        send_byte(CODE_SOH);
        for (int i = 0; i < len; i++)
            send_byte(frame[i]);
        if (len < FRAME_LEN)
        begin
            send_timeout();
        end
        else if (flaw == FLAW_NONE)
        begin
            next_seq = next_seq + 8'd1;
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom_range(0, 255)));
            send_timeout();
        end
    endtask

    // Result side: a random stall before each beat, and once on request a
    // long hold-off so the two register stages fill and evt.ready drops.
    initial
    begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_BEATS) @(posedge clk);
            end
            stall = no_gaps ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res_ch.valid);
        end
    end

    initial
    begin : stimulus
        int         choice;
        int         waited;
        flaw_t      flaw;
        logic [7:0] b;

        rst_n          = 1'b0;
        evt_ch.valid   <= 1'b0;
        evt_ch.kind    <= KIND_BYTE;
        evt_ch.rx_byte <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Before any packet, timeouts and stray bytes get NAK.
        send_timeout();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CODE_ACK);
        // CAN restarts and ACKs; EOT ACKs with the done flag and a zero count.
        send_byte(CODE_CAN);
        send_byte(CODE_EOT);
        // A timeout straight after SOH is a NAK in mid-packet.
        send_byte(CODE_SOH);
        send_timeout();
        // Once a packet has been seen, idle timeouts and junk stay silent.
        send_timeout();
        send_byte(8'hA5);
        send_byte(CODE_NAK);
        // Timeout after a good sequence byte, then CAN clears the seen flag
        // so an idle timeout is answered with NAK again.
        send_byte(CODE_SOH);
        send_byte(next_seq);
        send_timeout();
        send_byte(CODE_CAN);
        send_timeout();
        wait_replies_drained();

        // First random packet is a good one, sent against a long hold-off
        // on the result side.
        hold_request = 1'b1;
        send_packet(FLAW_NONE, FRAME_LEN, 1'b0);
        wait_replies_drained();

        // Random part: mostly complete packets with random content, plus
        // spoiled and cut-short packets, transfer ends, cancels and noise.
        while (sent < ITEM_COUNT)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            choice  = $urandom_range(0, 99);
            if (choice < 40)
            begin
                send_packet(FLAW_NONE, FRAME_LEN, $urandom_range(0, 3) == 0);
            end
            else if (choice < 52)
            begin
                flaw = flaw_t'($urandom_range(FLAW_SEQ, FLAW_SUM));
                send_packet(flaw, FRAME_LEN, $urandom_range(0, 3) == 0);
            end
            else if (choice < 65)
            begin
                send_packet(FLAW_NONE, ($urandom_range(0, 3) == 0)
                            ? $urandom_range(0, FRAME_LEN - 1) : $urandom_range(0, 6),
                            1'b0);
            end
            else if (choice < 75)
            begin
                if ($urandom_range(0, 1) == 0)
                    wait_replies_drained();
                send_byte(CODE_EOT);
                next_seq = 8'd1;
            end
            else if (choice < 82)
            begin
                send_byte(CODE_CAN);
                next_seq = 8'd1;
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_timeout();
                    end
                    else
                    begin
                        do
                            b = 8'($urandom_range(0, 255));
                        while (b == CODE_SOH || b == CODE_EOT || b == CODE_CAN);
                        send_byte(b);
                    end
                end
            end
        end

        // Drain: wait for the last predicted results, then a few more cycles
        // so a stray extra result would still be seen by the checker.
        no_gaps = 1'b0;
        evt_ch.valid <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);

        if (failures == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/xmcr_pkg.sv
hw/rtl/xmcr_if.sv
hw/rtl/xmodem_checksum_receiver.sv
bench/xmcr_reply_checker.sv
bench/xmodem_checksum_receiver_test.sv
